// ===== rtl/core/chd_pkg.sv =====
// Shared types and constants of the canonical Huffman decoder.
`default_nettype none
package chd_pkg;

	localparam int MAX_SYMBOLS_DEF     = 256;
	localparam int MAX_CODE_LENGTH_DEF = 16;

	localparam int MODE_W   = 3;
	localparam int INDEX_W  = 8;
	localparam int VALUE_W  = 9;
	localparam int SYMBOL_W = 8;
	localparam int LENGTH_W = 5;
	localparam int STATUS_W = 3;
	localparam int TOTAL_W  = 10;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_LOAD_COUNT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_SYMBOL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BIT         = 3'd3;
	localparam logic [MODE_W-1:0] MODE_END         = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_END       = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_TOO_LONG  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_BAD_TABLE = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd5;

	localparam logic [LENGTH_W-1:0] LEN_TOO_LONG = 5'd17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_DECODE,
		ST_READ,
		ST_EMIT
	} chd_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/canonical_huffman_decoder.sv =====
// Canonical Huffman decoder: table build sequencer, bit decoder and symbol store.
//
// Usage: configure symbol_count through cfg_wr_en/cfg_wr_data while idle, then send
// items on the s_ stream. s_tuser carries the mode; s_tdata carries the operands.
// Load-count and load-symbol items give no result.
// A finish item runs the table builder, one code length per cycle, and gives one
// result (status ok or bad table).
// A code bit item gives no result while the code is still partial; when it ends a
// code or hits an error it gives one result, after a further read step when the
// symbol store is read. The per-length compare and index add run in one decode
// step; the symbol store has a registered read port, which adds the read step.
// End-of-stream gives a result only when a partial code is pending.
// Results leave on the m_ stream from one output register. While it waits for
// m_tready the block still accepts the next item; a second result waits inside
// the block and holds off further input until the register frees.
// Reset clears the length counts, per-length flags and offsets, the partial code
// and the table-ready flag; no finished table exists until a finish item succeeds. The
// symbol store is not cleared; entries must be loaded before they are decoded.
`default_nettype none
module canonical_huffman_decoder #(
	parameter int MAX_SYMBOLS     = chd_pkg::MAX_SYMBOLS_DEF,
	parameter int MAX_CODE_LENGTH = chd_pkg::MAX_CODE_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [chd_pkg::VALUE_W-1:0]   cfg_wr_data,  // symbol_count
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [7:0] entry_index, [16:8] load_value, [17] stream_bit
	input  wire logic [chd_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [chd_pkg::MODE_W-1:0]    s_tuser,      // [2:0] mode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [chd_pkg::M_TDATA_W-1:0]      m_tdata,      // [7:0] symbol, [12:8] code_length
	output logic [chd_pkg::STATUS_W-1:0]       m_tuser       // [2:0] status
);
	import chd_pkg::*;

	localparam int SW = $clog2(MAX_SYMBOLS);
	localparam int LW = $clog2(MAX_CODE_LENGTH);
	localparam int BW = $clog2(MAX_CODE_LENGTH + 2);
	localparam int ML = MAX_CODE_LENGTH;
	localparam int IW = (MAX_CODE_LENGTH + 2 > TOTAL_W) ? MAX_CODE_LENGTH + 2 : TOTAL_W;

	chd_state_t state_q, state_d;

	logic [VALUE_W-1:0]  symbol_count_q;
	logic [VALUE_W-1:0]  counts_q [MAX_CODE_LENGTH];
	logic                has_q    [MAX_CODE_LENGTH];
	logic [ML-1:0]       max_q    [MAX_CODE_LENGTH];
	logic [IW-1:0]       off_q    [MAX_CODE_LENGTH];
	logic [SYMBOL_W-1:0] store_q  [MAX_SYMBOLS];

	logic                table_ready_q;
	logic [ML-1:0]       acc_q;
	logic [BW-1:0]       bits_q;
	logic                bit_q;

	logic [BW-1:0]       len_q;
	logic [IW-1:0]       code_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [SYMBOL_W-1:0] rd_q;
	logic [SYMBOL_W-1:0] res_symbol_q;
	logic [LENGTH_W-1:0] res_len_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                m_tvalid_q;
	logic [SYMBOL_W-1:0] m_symbol_q;
	logic [LENGTH_W-1:0] m_len_q;
	logic [STATUS_W-1:0] m_status_q;

	logic [MODE_W-1:0]   in_mode;
	logic [INDEX_W-1:0]  in_index;
	logic [VALUE_W-1:0]  in_value;
	logic                in_bit;
	logic                accept;
	logic                out_free;

	assign in_mode  = s_tuser;
	assign in_index = s_tdata[7:0];
	assign in_value = s_tdata[16:8];
	assign in_bit   = s_tdata[17];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// table builder step for length len_q
	logic [LW-1:0]      bidx;
	logic [VALUE_W-1:0] cnt;
	logic [TOTAL_W-1:0] tot_sum;
	logic [IW-1:0]      code_sum;
	logic               over_cap;
	logic               overfull;
	logic               build_last;

	assign bidx       = LW'(len_q - BW'(1));
	assign cnt        = counts_q[bidx];
	assign tot_sum    = total_q + TOTAL_W'(cnt);
	assign code_sum   = code_q + IW'(cnt);
	assign over_cap   = tot_sum > TOTAL_W'(MAX_SYMBOLS);
	assign overfull   = code_sum >= (IW'(1) << len_q);
	assign build_last = len_q == BW'(MAX_CODE_LENGTH);

	// decode step: shared compare and index add at length bits_q + 1
	logic [LW-1:0]      didx;
	logic [ML-1:0]      acc_n;
	logic [BW-1:0]      n_len;
	logic               too_long;
	logic               match;
	logic [IW-1:0]      sum;
	logic               neg;
	logic               over;
	logic [VALUE_W-1:0] limit;
	logic               empty;

	assign didx     = bits_q[LW-1:0];
	assign acc_n    = {acc_q[ML-2:0], bit_q};
	assign n_len    = bits_q + BW'(1);
	assign too_long = bits_q == BW'(MAX_CODE_LENGTH);
	assign match    = has_q[didx] && (acc_n <= max_q[didx]);
	assign sum      = IW'(acc_n) + off_q[didx];
	assign neg      = sum[IW-1];
	assign over     = !neg && (sum >= IW'(MAX_SYMBOLS));
	assign limit    = (symbol_count_q < VALUE_W'(MAX_SYMBOLS)) ? symbol_count_q
	                                                           : VALUE_W'(MAX_SYMBOLS);
	assign empty    = sum >= IW'(limit);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_FINISH: state_d = ST_BUILD;
						MODE_BIT:    state_d = ST_DECODE;
						MODE_END:    state_d = (bits_q != '0) ? ST_EMIT : ST_IDLE;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_BUILD: begin
				if (over_cap || overfull || build_last) state_d = ST_EMIT;
			end
			ST_DECODE: begin
				if (!table_ready_q || too_long) state_d = ST_EMIT;
				else if (!match) state_d = ST_IDLE;
				else if (neg || over || empty) state_d = ST_EMIT;
				else state_d = ST_READ;
			end
			ST_READ: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			symbol_count_q <= '0;
			table_ready_q  <= 1'b0;
			acc_q          <= '0;
			bits_q         <= '0;
			len_q          <= '0;
			code_q         <= '0;
			total_q        <= '0;
			m_tvalid_q     <= 1'b0;
			for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
				counts_q[i] <= '0;
				has_q[i]    <= 1'b0;
				off_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) symbol_count_q <= cfg_wr_data;
			if (state_q == ST_EMIT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_mode)
							MODE_LOAD_COUNT: begin
								if (in_index < INDEX_W'(MAX_CODE_LENGTH)) begin
									counts_q[in_index[LW-1:0]] <= in_value;
									table_ready_q <= 1'b0;
									acc_q  <= '0;
									bits_q <= '0;
								end
							end
							MODE_FINISH: begin
								len_q   <= BW'(1);
								code_q  <= '0;
								total_q <= '0;
								table_ready_q <= 1'b0;
								acc_q  <= '0;
								bits_q <= '0;
							end
							MODE_END: begin
								acc_q  <= '0;
								bits_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_BUILD: begin
					if (!over_cap) begin
						has_q[bidx] <= cnt != '0;
						off_q[bidx] <= IW'(total_q) - code_q;
					end
					if (!over_cap && !overfull) begin
						code_q  <= code_sum << 1;
						total_q <= tot_sum;
						len_q   <= len_q + BW'(1);
						if (build_last) table_ready_q <= 1'b1;
					end
				end
				ST_DECODE: begin
					if (!table_ready_q || too_long || match) begin
						acc_q  <= '0;
						bits_q <= '0;
					end else begin
						// hold the partial code
						acc_q  <= acc_n;
						bits_q <= n_len;
					end
				end
				default: ;
			endcase
		end
	end

	// payload: tables, symbol store, result staging and output register
	always_ff @(posedge clk) begin
		if (accept && in_mode == MODE_LOAD_SYMBOL && VALUE_W'(in_index) < VALUE_W'(MAX_SYMBOLS))
			store_q[in_index[SW-1:0]] <= in_value[SYMBOL_W-1:0];
		if (state_q == ST_DECODE) rd_q <= store_q[sum[SW-1:0]];
		if (state_q == ST_BUILD && !over_cap) max_q[bidx] <= ML'(code_sum - IW'(1));
		if (state_q == ST_IDLE && accept && in_mode == MODE_BIT) bit_q <= in_bit;

		case (state_q)
			ST_IDLE: begin
				res_symbol_q <= '0;
				res_len_q    <= '0;
				res_status_q <= STAT_END;
			end
			ST_BUILD: begin
				res_symbol_q <= '0;
				res_len_q    <= '0;
				res_status_q <= (over_cap || overfull) ? STAT_BAD_TABLE : STAT_OK;
			end
			ST_DECODE: begin
				res_symbol_q <= '0;
				if (!table_ready_q) begin
					res_len_q    <= '0;
					res_status_q <= STAT_BAD_TABLE;
				end else if (too_long) begin
					res_len_q    <= LEN_TOO_LONG;
					res_status_q <= STAT_TOO_LONG;
				end else begin
					res_len_q <= LENGTH_W'(n_len);
					if (neg || over) res_status_q <= STAT_BAD_INDEX;
					else if (empty) res_status_q <= STAT_EMPTY;
					else res_status_q <= STAT_OK;
				end
			end
			ST_READ: res_symbol_q <= rd_q;
			ST_EMIT: begin
				if (out_free) begin
					m_symbol_q <= res_symbol_q;
					m_len_q    <= res_len_q;
					m_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_len_q, m_symbol_q};
	assign m_tuser  = m_status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result appeared outside the emit step");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> table_ready_q && $past(state_q) == ST_DECODE)
		else $error("symbol read without a finished table");

	assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BW'(MAX_CODE_LENGTH))
		else $error("partial code longer than the longest length");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUILD |-> len_q >= BW'(1) && len_q <= BW'(MAX_CODE_LENGTH))
		else $error("table builder length out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECODE |-> $past(state_q) == ST_IDLE)
		else $error("decode step not started from idle");

endmodule
`default_nettype wire

// ===== bench/canonical_huffman_decoder_test.sv =====
// Stream testbench for the canonical Huffman decoder with a built-in decode predictor.
module canonical_huffman_decoder_test;
	import chd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_CYCLES = 400;
	localparam int STOP_CODE = 'hfffff;
	localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LAST = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [INDEX_W-1:0] entry_index;
		logic [VALUE_W-1:0] load_value;
		logic               stream_bit;
	} coded_item_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic [LENGTH_W-1:0] code_length;
		logic [STATUS_W-1:0] status;
	} decode_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [VALUE_W-1:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [MODE_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	canonical_huffman_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state as the testbench sees it
	logic [VALUE_W-1:0] sym_limit = '0;
	logic [VALUE_W-1:0] lens_count [MAX_CODE_LENGTH_DEF] = '{default: '0};
	logic [SYMBOL_W-1:0] stored_symbol [MAX_SYMBOLS_DEF];
	int largest_code [MAX_CODE_LENGTH_DEF+2] = '{default: -1};
	int offset_of_len [MAX_CODE_LENGTH_DEF+1] = '{default: 0};
	logic [16:0] partial_code = '0;
	int unsigned partial_bits = 0;
	logic table_valid = 1'b0;

	// code table the stimulus believes is loaded
	int unsigned gen_first [MAX_CODE_LENGTH_DEF+1];
	int unsigned gen_count [MAX_CODE_LENGTH_DEF+1];
	logic gen_table_ok = 1'b0;

	coded_item_t pending_items[$];
	coded_item_t on_bus;
	decode_result_t expected_results[$];
	int unsigned items_queued = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 29;
	int unsigned receiver_idle_pct = 84;
	logic stall_on = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < 100) begin
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		end
		error_count++;
	endtask

	function automatic void push_result(input logic [SYMBOL_W-1:0] sym,
			input logic [LENGTH_W-1:0] len, input logic [STATUS_W-1:0] st);
		decode_result_t r;
		r.symbol = sym;
		r.code_length = len;
		r.status = st;
		expected_results.push_back(r);
		partial_code = '0;
		partial_bits = 0;
	endfunction

	// assign canonical codes length by length; reject overfull tables and tables with too many codes
	function automatic logic derive_table();
		int unsigned total;
		int unsigned next_code;
		total = 0;
		next_code = 0;
		for (int l = 0; l < MAX_CODE_LENGTH_DEF + 2; l++) largest_code[l] = -1;
		for (int l = 0; l < MAX_CODE_LENGTH_DEF + 1; l++) offset_of_len[l] = 0;
		for (int l = 1; l <= MAX_CODE_LENGTH_DEF; l++) begin
			if (lens_count[l-1] + total > MAX_SYMBOLS_DEF) return 1'b0;
			if (lens_count[l-1] != 0) begin
				offset_of_len[l] = int'(total) - int'(next_code);
				largest_code[l] = int'(next_code + lens_count[l-1] - 1);
			end
			next_code += lens_count[l-1];
			total += lens_count[l-1];
			if (next_code >= (32'd1 << l)) return 1'b0;
			next_code <<= 1;
		end
		largest_code[MAX_CODE_LENGTH_DEF+1] = STOP_CODE;
		return 1'b1;
	endfunction

	function automatic void advance_decoder(input coded_item_t it);
		int acc;
		int idx;
		int unsigned avail;
		case (it.mode)
			MODE_LOAD_COUNT: begin
				if (it.entry_index < MAX_CODE_LENGTH_DEF) begin
					lens_count[it.entry_index[3:0]] = it.load_value;
					table_valid = 1'b0;
					partial_code = '0;
					partial_bits = 0;
				end
			end
			MODE_LOAD_SYMBOL: begin
				stored_symbol[it.entry_index] = it.load_value[SYMBOL_W-1:0];
			end
			MODE_FINISH: begin
				table_valid = derive_table();
				push_result('0, '0, table_valid ? STAT_OK : STAT_BAD_TABLE);
			end
			MODE_BIT: begin
				if (!table_valid) begin
					push_result('0, '0, STAT_BAD_TABLE);
				end else begin
					partial_code = {partial_code[15:0], it.stream_bit};
					partial_bits++;
					acc = int'(partial_code);
					if (partial_bits > MAX_CODE_LENGTH_DEF) begin
						push_result('0, LEN_TOO_LONG, STAT_TOO_LONG);
					end else if (acc <= largest_code[partial_bits]) begin
						idx = acc + offset_of_len[partial_bits];
						avail = (sym_limit < MAX_SYMBOLS_DEF) ? int'(sym_limit) : MAX_SYMBOLS_DEF;
						if (idx < 0 || idx >= MAX_SYMBOLS_DEF) begin
							push_result('0, LENGTH_W'(partial_bits), STAT_BAD_INDEX);
						end else if (idx >= int'(avail)) begin
							push_result('0, LENGTH_W'(partial_bits), STAT_EMPTY);
						end else begin
							push_result(stored_symbol[idx[SYMBOL_W-1:0]], LENGTH_W'(partial_bits),
								STAT_OK);
						end
					end
				end
			end
			MODE_END: begin
				if (partial_bits != 0) push_result('0, '0, STAT_END);
			end
			default: ;
		endcase
	endfunction

	// driver: present queued items, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) advance_decoder(on_bus);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					on_bus = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= S_TDATA_W'({on_bus.stream_bit, on_bus.load_value,
						on_bus.entry_index});
					s_tuser <= on_bus.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !stall_on && ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		decode_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with none pending, status", int'(m_tuser), -1);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[SYMBOL_W-1:0] !== want.symbol)
					report_mismatch("symbol", int'(m_tdata[SYMBOL_W-1:0]), int'(want.symbol));
				if (m_tdata[SYMBOL_W +: LENGTH_W] !== want.code_length)
					report_mismatch("code_length", int'(m_tdata[SYMBOL_W +: LENGTH_W]),
						int'(want.code_length));
				if (m_tuser !== want.status)
					report_mismatch("status", int'(m_tuser), int'(want.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("canonical_huffman_decoder_test: FAIL");
			$finish;
		end
	end

	function automatic void queue_item(input logic [MODE_W-1:0] mode,
			input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val, input logic b);
		coded_item_t it;
		it.mode = mode;
		it.entry_index = idx;
		it.load_value = val;
		it.stream_bit = b;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	// operand fields the mode ignores carry random junk
	function automatic void queue_op(input logic [MODE_W-1:0] mode);
		queue_item(mode, INDEX_W'($urandom_range(255)), VALUE_W'($urandom_range(511)),
			1'($urandom_range(1)));
	endfunction

	function automatic void queue_bit(input logic b);
		queue_item(MODE_BIT, INDEX_W'($urandom_range(255)), VALUE_W'($urandom_range(511)), b);
	endfunction

	function automatic void queue_code(input int unsigned code, input int unsigned len);
		for (int i = int'(len) - 1; i >= 0; i--) queue_bit(code[i]);
	endfunction

	function automatic void queue_count_table(input int unsigned counts [MAX_CODE_LENGTH_DEF]);
		for (int l = 0; l < MAX_CODE_LENGTH_DEF; l++) begin
			queue_item(MODE_LOAD_COUNT, INDEX_W'(l), VALUE_W'(counts[l]),
				1'($urandom_range(1)));
		end
		queue_op(MODE_FINISH);
	endfunction

	// random complete-enough table: keep the all-ones code of each length free
	function automatic void queue_random_table();
		int unsigned counts [MAX_CODE_LENGTH_DEF];
		int unsigned longest;
		int unsigned next_code;
		int unsigned total;
		int unsigned room;
		int unsigned cnt;
		longest = ($urandom_range(9) == 0) ? MAX_CODE_LENGTH_DEF : $urandom_range(1, 9);
		next_code = 0;
		total = 0;
		for (int l = 1; l <= MAX_CODE_LENGTH_DEF; l++) begin
			cnt = 0;
			if (l <= longest) begin
				room = (32'd1 << l) - next_code - 1;
				if (room > MAX_SYMBOLS_DEF - total) room = MAX_SYMBOLS_DEF - total;
				if (l < longest) begin
					cnt = ($urandom_range(9) == 0) ? $urandom_range(0, room)
						: $urandom_range(0, (room < 3) ? room : 3);
				end else begin
					cnt = $urandom_range((total == 0) ? 1 : 0, room);
				end
			end
			gen_first[l] = next_code;
			gen_count[l] = cnt;
			counts[l-1] = cnt;
			next_code = (next_code + cnt) << 1;
			total += cnt;
		end
		queue_count_table(counts);
		gen_table_ok = 1'b1;
	endfunction

	function automatic void queue_random_code();
		int unsigned l;
		do l = $urandom_range(1, MAX_CODE_LENGTH_DEF); while (gen_count[l] == 0);
		queue_code(gen_first[l] + $urandom_range(0, gen_count[l] - 1), l);
	endfunction

	function automatic void queue_random_stretch(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		int unsigned l;
		int unsigned counts [MAX_CODE_LENGTH_DEF];
		logic [MODE_W-1:0] mode;
		target = items_queued + count;
		while (items_queued < target) begin
			if (!gen_table_ok) queue_random_table();
			pick = $urandom_range(99);
			if (pick < 7) begin
				queue_random_table();
			end else if (pick < 15) begin
				mode = MODE_W'($urandom_range(7));
				queue_op(mode);
				if (mode == MODE_LOAD_COUNT) gen_table_ok = 1'b0;
			end else if (pick < 20) begin
				// cut a code short
				repeat ($urandom_range(1, 3)) queue_bit(1'($urandom_range(1)));
				queue_op(MODE_END);
			end else if (pick < 22) begin
				queue_op(MODE_END);
			end else if (pick < 24) begin
				repeat (MAX_CODE_LENGTH_DEF + 1) queue_bit(1'b1);
			end else if (pick < 26) begin
				counts = '{default: 0};
				if ($urandom_range(1)) begin
					l = $urandom_range(0, 7);
					counts[l] = 32'd1 << (l + 1);
				end else begin
					counts[MAX_CODE_LENGTH_DEF-2] = $urandom_range(1, MAX_SYMBOLS_DEF);
					counts[MAX_CODE_LENGTH_DEF-1] = MAX_SYMBOLS_DEF;
				end
				queue_count_table(counts);
				gen_table_ok = 1'b0;
			end else begin
				repeat ($urandom_range(1, 6)) queue_random_code();
			end
		end
	endfunction

	task automatic write_symbol_count(input int unsigned value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= VALUE_W'(value);
		sym_limit = VALUE_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned counts [MAX_CODE_LENGTH_DEF];
		int unsigned order [MAX_SYMBOLS_DEF];
		int unsigned j;
		int unsigned held;
		largest_code[MAX_CODE_LENGTH_DEF+1] = STOP_CODE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_symbol_count(MAX_SYMBOLS_DEF);

		// no table yet, idle end of stream, unused modes, ignored count writes
		queue_bit(1'b1);
		queue_op(MODE_END);
		for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) queue_op(MODE_W'(m));
		queue_item(MODE_LOAD_COUNT, 8'd16, 9'd5, 1'b0);
		queue_item(MODE_LOAD_COUNT, 8'd255, 9'd256, 1'b1);
		// empty table builds fine; a dangling bit then ends the stream mid-code
		queue_op(MODE_FINISH);
		queue_bit(1'b0);
		queue_op(MODE_END);

		// fill the whole symbol store in shuffled order
		for (int i = 0; i < MAX_SYMBOLS_DEF; i++) order[i] = i;
		for (int i = MAX_SYMBOLS_DEF - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			held = order[i];
			order[i] = order[j];
			order[j] = held;
		end
		for (int i = 0; i < MAX_SYMBOLS_DEF; i++) begin
			queue_item(MODE_LOAD_SYMBOL, INDEX_W'(order[i]),
				(order[i] == 0) ? 9'h1ff : (order[i] == 255) ? 9'h100
				: VALUE_W'($urandom_range(511)), 1'($urandom_range(1)));
		end

		// all 256 codes at the longest length: first and last entry
		counts = '{default: 0};
		counts[MAX_CODE_LENGTH_DEF-1] = MAX_SYMBOLS_DEF;
		queue_count_table(counts);
		queue_code(0, MAX_CODE_LENGTH_DEF);
		queue_code(MAX_SYMBOLS_DEF - 1, MAX_CODE_LENGTH_DEF);
		// overfull length, then too many codes in total
		counts = '{default: 0};
		counts[0] = 2;
		queue_count_table(counts);
		queue_bit(1'b0);
		counts = '{default: 0};
		counts[8] = MAX_SYMBOLS_DEF;
		counts[9] = 1;
		queue_count_table(counts);
		// single one-bit code: overrun with ones, decode it, clear a partial code
		counts = '{default: 0};
		counts[0] = 1;
		queue_count_table(counts);
		repeat (MAX_CODE_LENGTH_DEF + 1) queue_bit(1'b1);
		queue_code(0, 1);
		queue_bit(1'b1);
		queue_item(MODE_LOAD_COUNT, 8'd0, 9'd1, 1'b0);
		queue_op(MODE_END);
		queue_bit(1'b0);
		queue_op(MODE_FINISH);
		gen_table_ok = 1'b0;
		queue_random_stretch(420 - items_queued);
		wait_drained();

		sender_idle_pct = 84;
		receiver_idle_pct = 29;
		write_symbol_count(MAX_SYMBOLS_DEF - 1);
		// last store entry is now beyond the supplied symbols
		counts = '{default: 0};
		counts[MAX_CODE_LENGTH_DEF-1] = MAX_SYMBOLS_DEF;
		queue_count_table(counts);
		queue_code(MAX_SYMBOLS_DEF - 1, MAX_CODE_LENGTH_DEF);
		queue_code(MAX_SYMBOLS_DEF - 2, MAX_CODE_LENGTH_DEF);
		gen_table_ok = 1'b0;
		queue_random_stretch(150);
		wait_drained();

		write_symbol_count(0);
		queue_random_stretch(60);
		wait_drained();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_symbol_count($urandom_range(1, MAX_SYMBOLS_DEF - 2));
		queue_random_stretch(150);
		// hold the output back so the block backs up into its input
		@(posedge clk);
		stall_on <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		stall_on <= 1'b0;
		wait_drained();

		write_symbol_count(9'h1ff);
		queue_random_stretch(80);
		wait_drained();

		if (error_count == 0 && expected_results.size() == 0) begin
			$display("canonical_huffman_decoder_test: PASS");
		end else begin
			$display("canonical_huffman_decoder_test: FAIL");
		end
		$finish;
	end

endmodule
